// ----- rtl/bcc_pkg.sv -----
// shared types, opcodes and widths for the bytecode constraint checker
package bcc_pkg;

  localparam int PROG_DEPTH_DEF = 64;

  localparam int ADDR_IN_W  = 6;
  localparam int BYTE_W     = 8;
  localparam int SAMPLE_W   = 32;
  localparam int PLEN_W     = 7;
  localparam int BUDGET_W   = 16;
  localparam int CAUSE_W    = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // opcodes
  localparam logic [BYTE_W-1:0] OP_HALT   = 8'h00;
  localparam logic [BYTE_W-1:0] OP_RANGE  = 8'h01;
  localparam logic [BYTE_W-1:0] OP_AND    = 8'h02;
  localparam logic [BYTE_W-1:0] OP_OR     = 8'h03;
  localparam logic [BYTE_W-1:0] OP_ASSERT = 8'h04;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROG_LEN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OP_BUDGET = 2'd1;

  typedef enum logic [CAUSE_W-1:0] {
    STOP_HALT    = 3'd0,
    STOP_END     = 3'd1,
    STOP_BUDGET  = 3'd2,
    STOP_UNKNOWN = 3'd3,
    STOP_TRUNC   = 3'd4
  } stop_cause_t;

  typedef struct packed {
    logic        start;
    logic        prog_wr;
    logic        fetch_op;
    logic        fetch_opnd;
    logic        op_and;
    logic        op_or;
    logic        op_assert;
    logic        shift_opnd;
    logic        apply_range;
    logic        set_cause;
    stop_cause_t cause;
    logic        load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic              at_end;
    logic              budget_spent;
    logic              trunc;
    logic              out_busy;
    logic [BYTE_W-1:0] op;
  } dp_status_t;

endpackage

// ----- rtl/bcc_item_if.sv -----
// input item channel
interface bcc_item_if;
  import bcc_pkg::*;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [ADDR_IN_W-1:0]        prog_addr;
  logic [BYTE_W-1:0]           prog_byte;
  logic signed [SAMPLE_W-1:0]  sample;
  logic                        last_element;
  modport source (output valid, action, prog_addr, prog_byte, sample, last_element,
                  input ready);
  modport sink (input valid, action, prog_addr, prog_byte, sample, last_element,
                output ready);
endinterface

// ----- rtl/bcc_result_if.sv -----
// result item channel
interface bcc_result_if;
  import bcc_pkg::*;
  logic                        valid;
  logic                        ready;
  logic signed [SAMPLE_W-1:0]  result_value;
  logic                        element_fault;
  logic [CAUSE_W-1:0]          stop_cause;
  logic                        batch_fault;
  modport source (output valid, result_value, element_fault, stop_cause, batch_fault,
                  input ready);
  modport sink (input valid, result_value, element_fault, stop_cause, batch_fault,
                output ready);
endinterface

// ----- rtl/bcc_cfg_if.sv -----
// configuration write channel
interface bcc_cfg_if;
  import bcc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/bcc_ctrl.sv -----
// fetch/decode sequencer for the program walk
module bcc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic                item_action,
  output logic                item_ready,
  input  bcc_pkg::dp_status_t status,
  output bcc_pkg::dp_cmd_t    cmd
);
  import bcc_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    CHECK,
    DECODE,
    OPND,
    RANGE_CMP,
    DONE
  } state_t;

  localparam logic [2:0] OPND_LAST = 3'd7;

  state_t     state, state_next;
  logic [2:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == DECODE) begin
        cnt <= '0;
      end else if (state == OPND) begin
        cnt <= cnt + 3'd1;
      end
    end
  end

  assign item_ready = (state == IDLE);

  always_comb begin
    cmd        = '0;
    cmd.cause  = STOP_HALT;
    state_next = state;
    unique case (state)
      IDLE: begin
        if (item_valid) begin
          if (item_action) begin
            cmd.start  = 1'b1;
            state_next = CHECK;
          end else begin
            cmd.prog_wr = 1'b1;
          end
        end
      end
      CHECK: begin
        // end of program is tested before the budget
        priority if (status.at_end) begin
          cmd.set_cause = 1'b1;
          cmd.cause     = STOP_END;
          state_next    = DONE;
        end else if (status.budget_spent) begin
          cmd.set_cause = 1'b1;
          cmd.cause     = STOP_BUDGET;
          state_next    = DONE;
        end else begin
          cmd.fetch_op = 1'b1;
          state_next   = DECODE;
        end
      end
      DECODE: begin
        unique case (status.op)
          OP_HALT: begin
            cmd.set_cause = 1'b1;
            cmd.cause     = STOP_HALT;
            state_next    = DONE;
          end
          OP_RANGE: begin
            if (status.trunc) begin
              cmd.set_cause = 1'b1;
              cmd.cause     = STOP_TRUNC;
              state_next    = DONE;
            end else begin
              cmd.fetch_opnd = 1'b1;
              state_next     = OPND;
            end
          end
          OP_AND: begin
            cmd.op_and = 1'b1;
            state_next = CHECK;
          end
          OP_OR: begin
            cmd.op_or  = 1'b1;
            state_next = CHECK;
          end
          OP_ASSERT: begin
            cmd.op_assert = 1'b1;
            state_next    = CHECK;
          end
          default: begin
            cmd.set_cause = 1'b1;
            cmd.cause     = STOP_UNKNOWN;
            state_next    = DONE;
          end
        endcase
      end
      OPND: begin
        cmd.shift_opnd = 1'b1;
        if (cnt == OPND_LAST) begin
          state_next = RANGE_CMP;
        end else begin
          cmd.fetch_opnd = 1'b1;
        end
      end
      RANGE_CMP: begin
        cmd.apply_range = 1'b1;
        state_next      = CHECK;
      end
      DONE: begin
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/bcc_dpath.sv -----
// program store, config registers, result word and output register
module bcc_dpath #(
  parameter int PROG_DEPTH = bcc_pkg::PROG_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  bcc_pkg::dp_cmd_t                    cmd,
  output bcc_pkg::dp_status_t                 status,
  input  logic                                cfg_we,
  input  logic [bcc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bcc_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [bcc_pkg::ADDR_IN_W-1:0]       prog_addr,
  input  logic [bcc_pkg::BYTE_W-1:0]          prog_byte,
  input  logic signed [bcc_pkg::SAMPLE_W-1:0] sample,
  input  logic                                last_element,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [bcc_pkg::SAMPLE_W-1:0] result_value,
  output logic                                element_fault,
  output logic [bcc_pkg::CAUSE_W-1:0]         stop_cause,
  output logic                                batch_fault
);
  import bcc_pkg::*;

  localparam int AW = (PROG_DEPTH > 1) ? $clog2(PROG_DEPTH) : 1;
  localparam int LW = $clog2(PROG_DEPTH + 1);
  localparam int CW = (LW > PLEN_W) ? LW : PLEN_W;

  logic [PLEN_W-1:0]          program_length;
  logic [BUDGET_W-1:0]        op_budget;
  logic [BYTE_W-1:0]          mem [PROG_DEPTH];
  logic [BYTE_W-1:0]          rdata;
  logic [LW-1:0]              ip;
  logic [LW-1:0]              len;
  logic [CW-1:0]              plen_w;
  logic [BUDGET_W-1:0]        used;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic                       last_q;
  logic [SAMPLE_W-1:0]        res;
  logic                       fault;
  logic                       fault_seen;
  logic                       fs_new;
  logic [2*SAMPLE_W-1:0]      opnd;
  logic signed [SAMPLE_W-1:0] lo;
  logic signed [SAMPLE_W-1:0] hi;
  stop_cause_t                cause;
  logic                       wr_ok;
  logic [AW-1:0]              wr_idx;
  logic                       rd_en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      program_length <= '0;
      op_budget      <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PROG_LEN:  program_length <= cfg_data[PLEN_W-1:0];
        REG_OP_BUDGET: op_budget      <= cfg_data[BUDGET_W-1:0];
        default: ;
      endcase
    end
  end

  // length saturates at the store depth
  assign plen_w = CW'(program_length);
  assign len    = (plen_w > CW'(PROG_DEPTH)) ? LW'(PROG_DEPTH) : LW'(plen_w);

  assign wr_ok  = (int'(prog_addr) < PROG_DEPTH);
  assign wr_idx = AW'(prog_addr);
  assign rd_en  = cmd.fetch_op | cmd.fetch_opnd;

  // program store, registered read
  always_ff @(posedge clk) begin
    if (cmd.prog_wr && wr_ok) begin
      mem[wr_idx] <= prog_byte;
    end
    if (rd_en) begin
      rdata <= mem[ip[AW-1:0]];
    end
  end

  assign lo     = opnd[SAMPLE_W-1:0];
  assign hi     = opnd[2*SAMPLE_W-1:SAMPLE_W];
  assign fs_new = fault_seen | fault;

  always_ff @(posedge clk) begin
    if (rst) begin
      fault_seen <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        fault_seen <= last_q ? 1'b0 : fs_new;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ip       <= '0;
      used     <= '0;
      res      <= SAMPLE_W'(1);
      fault    <= 1'b0;
      sample_q <= sample;
      last_q   <= last_element;
    end
    if (rd_en) begin
      ip <= ip + LW'(1);
    end
    if (cmd.fetch_op) begin
      used <= used + BUDGET_W'(1);
    end
    if (cmd.op_and) begin
      res <= res & sample_q;
    end
    if (cmd.op_or) begin
      res <= res | sample_q;
    end
    if (cmd.op_assert && (res == '0)) begin
      fault <= 1'b1;
    end
    // little-endian bytes shift in from the top
    if (cmd.shift_opnd) begin
      opnd <= {rdata, opnd[2*SAMPLE_W-1:BYTE_W]};
    end
    if (cmd.apply_range) begin
      res <= SAMPLE_W'((sample_q >= lo) && (sample_q <= hi));
    end
    if (cmd.set_cause) begin
      cause <= cmd.cause;
    end
    if (cmd.load_out) begin
      result_value  <= res;
      element_fault <= fault;
      stop_cause    <= cause;
      batch_fault   <= last_q & fs_new;
    end
  end

  assign status.at_end       = (ip >= len);
  assign status.budget_spent = (used >= op_budget);
  assign status.trunc        = ((len - ip) < LW'(8));
  assign status.out_busy     = out_valid & ~out_ready;
  assign status.op           = rdata;

endmodule

// ----- rtl/bytecode_constraint_checker_top.sv -----
// bytecode constraint checker: each sample runs the stored byte program
// a check tests end and budget before each opcode, then fetches and decodes it; a complete
//   RANGE then fetches its operands and compares; a walk stopped by HALT, an
//   unknown opcode or a truncated RANGE skips the final end check
//   (one store read per cycle; a RANGE reads its eight operand bytes one at a time)
// a program write is taken while idle and gives no result
// throughput: one item at a time; the next item is taken once the result is in the output register
// reset (rst, synchronous): length 0, budget 65535, batch fault cleared; store contents undefined
module bytecode_constraint_checker_top #(
  parameter int PROG_DEPTH = bcc_pkg::PROG_DEPTH_DEF
) (
  input logic         clk,
  input logic         rst,
  bcc_item_if.sink    item,
  bcc_result_if.source result,
  bcc_cfg_if.sink     cfg
);
  import bcc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       item_ready;

  // config writes always taken; host must send them only while the block is idle (unenforced)
  assign cfg.ready  = 1'b1;
  assign item.ready = item_ready;

  // controller walks the program: check end/budget, fetch, decode, operands
  bcc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item.valid),
    .item_action (item.action),
    .item_ready  (item_ready),
    .status      (status),
    .cmd         (cmd)
  );

  // datapath holds the store, the result word and the output register
  bcc_dpath #(
    .PROG_DEPTH (PROG_DEPTH)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_we        (cfg.valid),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data),
    .prog_addr     (item.prog_addr),
    .prog_byte     (item.prog_byte),
    .sample        (item.sample),
    .last_element  (item.last_element),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .result_value  (result.result_value),
    .element_fault (result.element_fault),
    .stop_cause    (result.stop_cause),
    .batch_fault   (result.batch_fault)
  );

endmodule

// ----- rtl/bcc_checker.sv -----
// port-level assertions for the checker top, bound in below
module bcc_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                item_valid,
  input logic                                item_ready,
  input logic                                item_action,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [bcc_pkg::SAMPLE_W-1:0] result_value,
  input logic                                element_fault,
  input logic [bcc_pkg::CAUSE_W-1:0]         stop_cause,
  input logic                                batch_fault
);
  import bcc_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_value)
      && $stable(element_fault) && $stable(stop_cause) && $stable(batch_fault))
    else $error("result changed while stalled");

  // stop cause stays in its legal codes
  a_cause_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (stop_cause <= STOP_TRUNC))
    else $error("illegal stop cause");

  // a check transfer keeps the input closed the next cycle
  a_busy_after_check: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item_action |=> !item_ready)
    else $error("input reopened right after a check");

  // no result comes out the cycle after a check transfer
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item_action |=> !$rose(out_valid))
    else $error("result appeared too early");

  // a program write never causes a result
  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && !item_action && !out_valid |=> !out_valid)
    else $error("result after a program write");

endmodule

bind bytecode_constraint_checker_top bcc_checker u_bcc_checker (
  .clk           (clk),
  .rst           (rst),
  .item_valid    (item.valid),
  .item_ready    (item.ready),
  .item_action   (item.action),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .result_value  (result.result_value),
  .element_fault (result.element_fault),
  .stop_cause    (result.stop_cause),
  .batch_fault   (result.batch_fault)
);

// ----- tb/bytecode_constraint_checker_top_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the bytecode constraint checker top level
module bytecode_constraint_checker_top_tb;
  import bcc_pkg::*;

  localparam int STORE_DEPTH   = PROG_DEPTH_DEF;
  localparam int MAX_SHOWN     = 10;
  localparam int SETTLE_CYCLES = 150;  // longer than a full 64-opcode walk
  localparam int TARGET_ITEMS  = 1900;
  localparam logic ACT_WRITE   = 1'b0;
  localparam logic ACT_CHECK   = 1'b1;

  // one input item as queued for the driver
  typedef struct {
    logic                 action;
    logic [ADDR_IN_W-1:0] addr;
    logic [BYTE_W-1:0]    pbyte;
    logic [SAMPLE_W-1:0]  sample;
    logic                 last;
    logic                 sync;    // hold this item back until all results are in
  } stim_t;

  // what one checked sample must produce
  typedef struct {
    logic [SAMPLE_W-1:0] value;
    logic                fault;
    stop_cause_t         cause;
    logic                batch;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bcc_item_if   item_ch ();
  bcc_result_if result_ch ();
  bcc_cfg_if    cfg_ch ();

  bytecode_constraint_checker_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always #10 clk = ~clk;

  // shadow copy of the block state, updated at each accepted transfer
  logic [BYTE_W-1:0]   store_img [STORE_DEPTH];
  logic [PLEN_W-1:0]   len_reg    = '0;
  logic [BUDGET_W-1:0] budget_reg = '1;
  logic                batch_acc  = 1'b0;

  stim_t    pending_items [$];
  verdict_t expected_results [$];

  // program image under construction and the range bounds it uses
  logic [BYTE_W-1:0]   prog_img [$];
  logic [SAMPLE_W-1:0] bound_pool [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  int n_queued       = 0;
  int n_checks       = 0;
  int n_writes       = 0;
  int n_cfg          = 0;
  int n_faults       = 0;
  int n_batch        = 0;
  int cause_hits [5] = '{default: 0};

  function automatic void note_failure(input string msg);
    mismatches++;
    if (mismatches <= MAX_SHOWN) $display("[%0t] mismatch: %s", $time, msg);
  endfunction

  // walk the stored program for one sample and fold its fault into the batch
  function automatic verdict_t predict_check(input logic [SAMPLE_W-1:0] raw,
                                             input logic last);
    verdict_t v;
    int eff_len;
    int ip;
    int used;
    logic done;
    logic [BYTE_W-1:0] op;
    logic signed [SAMPLE_W-1:0] s;
    logic signed [SAMPLE_W-1:0] lo;
    logic signed [SAMPLE_W-1:0] hi;
    s = raw;
    // a length past the store reads as the whole store
    eff_len = (len_reg > STORE_DEPTH) ? STORE_DEPTH : int'(len_reg);
    v.value = 32'd1;
    v.fault = 1'b0;
    v.cause = STOP_END;
    v.batch = 1'b0;
    ip = 0;
    used = 0;
    done = 1'b0;
    while (!done) begin
      // end of program is tested before the budget
      if (ip >= eff_len) begin
        v.cause = STOP_END;
        done = 1'b1;
      end else if (used >= int'(budget_reg)) begin
        v.cause = STOP_BUDGET;
        done = 1'b1;
      end else begin
        used++;
        op = store_img[ip];
        ip++;
        case (op)
          OP_HALT: begin
            v.cause = STOP_HALT;
            done = 1'b1;
          end
          OP_RANGE: begin
            if (eff_len - ip < 8) begin
              v.cause = STOP_TRUNC;
              done = 1'b1;
            end else begin
              lo = {store_img[ip+3], store_img[ip+2], store_img[ip+1], store_img[ip]};
              hi = {store_img[ip+7], store_img[ip+6], store_img[ip+5], store_img[ip+4]};
              ip += 8;
              v.value = (s >= lo && s <= hi) ? 32'd1 : 32'd0;
            end
          end
          OP_AND: v.value = v.value & raw;
          OP_OR: v.value = v.value | raw;
          OP_ASSERT: begin
            if (v.value == 0) v.fault = 1'b1;
          end
          default: begin
            v.cause = STOP_UNKNOWN;
            done = 1'b1;
          end
        endcase
      end
    end
    batch_acc = batch_acc | v.fault;
    if (last) begin
      v.batch = batch_acc;
      batch_acc = 1'b0;
    end
    cause_hits[int'(v.cause)]++;
    if (v.fault) n_faults++;
    if (v.batch) n_batch++;
    return v;
  endfunction

  // driver: a new item goes out when the channel is free and the sender is not idling
  stim_t on_bus;
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else begin
      // transfer completes at this edge: predict from the state before it
      if (item_ch.valid && item_ch.ready) begin
        if (on_bus.action == ACT_CHECK) begin
          expected_results.push_back(predict_check(on_bus.sample, on_bus.last));
          n_checks++;
        end else begin
          store_img[on_bus.addr] = on_bus.pbyte;
          n_writes++;
        end
      end
      if (!item_ch.valid || item_ch.ready) begin
        if (pending_items.size() != 0 &&
            !(pending_items[0].sync && expected_results.size() != 0) &&
            $urandom_range(99) >= send_idle_pct) begin
          on_bus = pending_items.pop_front();
          item_ch.action       <= on_bus.action;
          item_ch.prog_addr    <= on_bus.addr;
          item_ch.prog_byte    <= on_bus.pbyte;
          item_ch.sample       <= on_bus.sample;
          item_ch.last_element <= on_bus.last;
          item_ch.valid        <= 1'b1;
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: every result transfer is matched against the oldest expectation
  verdict_t want;
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_results.size() == 0) begin
          note_failure($sformatf("result with nothing expected: value %h cause %0d",
                                 result_ch.result_value, result_ch.stop_cause));
        end else begin
          want = expected_results.pop_front();
          if (result_ch.result_value !== want.value ||
              result_ch.element_fault !== want.fault ||
              result_ch.stop_cause !== want.cause ||
              result_ch.batch_fault !== want.batch)
            note_failure($sformatf(
              "expected value %h fault %b cause %0d batch %b, got %h %b %0d %b",
              want.value, want.fault, want.cause, want.batch,
              result_ch.result_value, result_ch.element_fault,
              result_ch.stop_cause, result_ch.batch_fault));
        end
      end
      result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic push_write(input int addr, input int val);
    stim_t it;
    it.action = ACT_WRITE;
    it.addr   = ADDR_IN_W'(addr);
    it.pbyte  = BYTE_W'(val);
    it.sample = $urandom;              // don't-care fields still toggle
    it.last   = 1'($urandom_range(1)); // last on a write must not touch the batch
    it.sync   = 1'b0;
    pending_items.push_back(it);
    n_queued++;
  endtask

  task automatic push_check(input logic [SAMPLE_W-1:0] smp, input logic last,
                            input logic sync);
    stim_t it;
    it.action = ACT_CHECK;
    it.addr   = ADDR_IN_W'($urandom_range(63));
    it.pbyte  = BYTE_W'($urandom_range(255));
    it.sample = smp;
    it.last   = last;
    it.sync   = sync;
    pending_items.push_back(it);
    n_queued++;
  endtask

  // little-endian operand word for a range
  task automatic append_word(input logic [SAMPLE_W-1:0] w);
    for (int b = 0; b < 4; b++) prog_img.push_back(w[8*b +: 8]);
  endtask

  task automatic load_program();
    for (int k = 0; k < prog_img.size(); k++) push_write(k, int'(prog_img[k]));
  endtask

  // mostly short programs, now and then a long one; ranges kept whole inside the store
  task automatic compose_program();
    int n_ops;
    int pick;
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] hi;
    logic [SAMPLE_W-1:0] mid;
    logic [SAMPLE_W-1:0] span;
    prog_img.delete();
    bound_pool.delete();
    n_ops = ($urandom_range(7) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 7);
    for (int k = 0; k < n_ops && prog_img.size() < STORE_DEPTH; k++) begin
      pick = $urandom_range(99);
      if (pick < 35 && prog_img.size() <= STORE_DEPTH - 9) begin
        case ($urandom_range(3))
          0: begin
            mid = $urandom_range(400) - 200;
            span = $urandom_range(60);
            lo = mid - span;
            hi = mid + span;
          end
          1: begin
            // independent bounds, inverted about half the time
            lo = $urandom;
            hi = $urandom;
          end
          2: begin
            lo = 32'h8000_0000;
            hi = $urandom_range(200) - 100;
          end
          default: begin
            lo = $urandom_range(200) - 100;
            hi = 32'h7fff_ffff;
          end
        endcase
        prog_img.push_back(OP_RANGE);
        append_word(lo);
        append_word(hi);
        bound_pool.push_back(lo);
        bound_pool.push_back(hi);
      end else if (pick < 50) begin
        prog_img.push_back(OP_AND);
      end else if (pick < 65) begin
        prog_img.push_back(OP_OR);
      end else if (pick < 88) begin
        prog_img.push_back(OP_ASSERT);
      end else if (pick < 95) begin
        prog_img.push_back(OP_HALT);
      end else begin
        prog_img.push_back(BYTE_W'($urandom_range(OP_ASSERT + 1, 255)));
      end
    end
  endtask

  // samples cluster on the range edges so both outcomes of each compare show up
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(99);
    if (r < 40 && bound_pool.size() != 0)
      return bound_pool[$urandom_range(bound_pool.size() - 1)] + $urandom_range(2) - 1;
    if (r < 52) begin
      case ($urandom_range(4))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h0000_0000;
        3: return 32'hffff_ffff;
        default: return 32'h0000_0001;
      endcase
    end
    if (r < 72) return $urandom_range(600) - 300;
    return $urandom;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_PROG_LEN) len_reg = val[PLEN_W-1:0];
    else if (idx == REG_OP_BUDGET) budget_reg = val;
    n_cfg++;
  endtask

  // block is idle once the queue is empty, the channel is quiet and every result is in;
  // the extra cycles cover a program write that is still being taken
  task automatic wait_idle();
    @(posedge clk);
    while (pending_items.size() != 0 || item_ch.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] len_word,
                            input logic [CFG_DATA_W-1:0] budget_word);
    wait_idle();
    write_reg(REG_PROG_LEN, len_word);
    write_reg(REG_OP_BUDGET, budget_word);
  endtask

  initial begin
    int phase;
    int r;
    int plen;
    int n_chk;
    int sync_at;
    logic [CFG_DATA_W-1:0] len_word;
    logic [CFG_DATA_W-1:0] budget_word;

    item_ch.valid        = 1'b0;
    item_ch.action       = ACT_WRITE;
    item_ch.prog_addr    = '0;
    item_ch.prog_byte    = '0;
    item_ch.sample       = '0;
    item_ch.last_element = 1'b0;
    result_ch.ready      = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = REG_PROG_LEN;
    cfg_ch.data          = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed part, with gaps on both sides
    send_idle_pct  = 31;
    recv_stall_pct = 31;

    // empty program ends at its end even with no budget at all
    set_config(16'd0, 16'd0);
    push_check(32'h0000_1234, 1'b0, 1'b0);

    // define every store byte before any length can reach it
    for (int a = 0; a < STORE_DEPTH; a++) push_write(a, int'(OP_ASSERT));

    // length past the store walks all 64 bytes; upper data bits are dropped
    set_config(16'hFFFF, 16'hFFFF);
    push_check(32'h7fff_ffff, 1'b1, 1'b0);

    // budget one short of the whole store
    set_config(16'd64, 16'd63);
    push_check(32'h0000_0000, 1'b0, 1'b0);

    // range -100..100, assert, and, assert, or, halt
    prog_img.delete();
    prog_img.push_back(OP_RANGE);
    append_word(-32'sd100);
    append_word(32'sd100);
    prog_img.push_back(OP_ASSERT);
    prog_img.push_back(OP_AND);
    prog_img.push_back(OP_ASSERT);
    prog_img.push_back(OP_OR);
    prog_img.push_back(OP_HALT);
    load_program();
    set_config(16'd14, 16'hFFFF);
    push_check(32'h0000_0000, 1'b0, 1'b0);
    push_check(-32'sd100, 1'b0, 1'b0);
    push_check(32'd100, 1'b1, 1'b0);
    push_check(-32'sd101, 1'b0, 1'b1);
    push_check(32'd101, 1'b0, 1'b0);
    push_check(32'h8000_0000, 1'b1, 1'b0);
    push_check(32'h7fff_ffff, 1'b0, 1'b0);
    push_check(32'hffff_ffff, 1'b1, 1'b0);

    // range with only seven operand bytes before the end
    push_write(0, int'(OP_RANGE));
    set_config(16'd8, 16'hFFFF);
    push_check(32'h0000_0055, 1'b0, 1'b0);

    // unknown opcodes, the smallest and the largest
    push_write(0, 255);
    push_check(32'h0000_0003, 1'b0, 1'b0);
    push_write(0, int'(OP_ASSERT) + 1);
    push_check(32'h0000_0003, 1'b1, 1'b0);

    // budget of zero with a program present
    push_write(0, int'(OP_OR));
    push_write(1, int'(OP_OR));
    push_write(2, int'(OP_OR));
    set_config(16'd3, 16'd0);
    push_check(32'h0f0f_0000, 1'b0, 1'b0);

    // single-byte program that runs off its end
    set_config(16'd1, 16'hFFFF);
    push_check(32'h00f0_0000, 1'b1, 1'b0);

    // random programs, one per phase, each under its own settings and idling mode
    phase = 0;
    while (n_queued < TARGET_ITEMS) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      compose_program();
      load_program();

      r = $urandom_range(99);
      if (r < 70) plen = prog_img.size();
      else if (r < 82) plen = $urandom_range(0, prog_img.size());  // may cut a range
      else if (r < 92) plen = $urandom_range(prog_img.size(), STORE_DEPTH);
      else plen = $urandom_range(STORE_DEPTH + 1, 127);
      len_word = '0;
      len_word[PLEN_W-1:0] = PLEN_W'(plen);
      if ($urandom_range(9) < 3)
        len_word[CFG_DATA_W-1:PLEN_W] = (CFG_DATA_W - PLEN_W)'($urandom_range(511));

      r = $urandom_range(99);
      if (r < 55) budget_word = 16'hFFFF;
      else if (r < 75) budget_word = CFG_DATA_W'($urandom_range(0, 12));
      else if (r < 90) budget_word = CFG_DATA_W'($urandom_range(13, 200));
      else budget_word = CFG_DATA_W'($urandom_range(0, 65535));
      set_config(len_word, budget_word);

      n_chk = $urandom_range(40, 80);
      sync_at = $urandom_range(n_chk - 1);
      for (int k = 0; k < n_chk; k++) begin
        // stray writes keep the store moving under a running stream
        if ($urandom_range(99) < 6) push_write($urandom_range(63), $urandom_range(255));
        push_check(pick_sample(), $urandom_range(4) == 0, k == sync_at);
      end
      phase++;
    end

    wait_idle();
    $display("run covered %0d checked samples, %0d program byte writes, %0d register writes",
             n_checks, n_writes, n_cfg);
    $display("stops: halt %0d end %0d budget %0d unknown %0d truncated %0d; faults %0d, batch %0d",
             cause_hits[STOP_HALT], cause_hits[STOP_END], cause_hits[STOP_BUDGET],
             cause_hits[STOP_UNKNOWN], cause_hits[STOP_TRUNC], n_faults, n_batch);
    if (mismatches == 0) begin
      $display("bytecode_constraint_checker_top regression: pass");
    end else begin
      $display("bytecode_constraint_checker_top regression: fail");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #100_000_000;
    $display("timeout with %0d results still expected", expected_results.size());
    $display("bytecode_constraint_checker_top regression: fail");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/bcc_pkg.sv
rtl/bcc_item_if.sv
rtl/bcc_result_if.sv
rtl/bcc_cfg_if.sv
rtl/bcc_ctrl.sv
rtl/bcc_dpath.sv
rtl/bytecode_constraint_checker_top.sv
rtl/bcc_checker.sv
tb/bytecode_constraint_checker_top_tb.sv
